// File: hdl/pqrm_pkg.sv
// Shared types, codes and constants of the priority queue with remove by id.
`timescale 1ns / 1ps
package pqrm_pkg;

  localparam int CAPACITY_DEF      = 16;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int ACT_W     = 2;
  localparam int PRIO_IN_W = 8;
  localparam int ID_W      = 16;
  localparam int TAG_W     = 32;
  localparam int OCC_W     = 5;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic            REG_FIRST_ID = 1'b0;
  localparam logic [ID_W-1:0] FIRST_ID_RST = '0;

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [PRIO_IN_W-1:0] priority_req;
    logic [TAG_W-1:0]     tag;
    logic [ID_W-1:0]      search_id;
  } pqrm_in_t;

  typedef struct packed {
    logic                 ok;
    logic [ID_W-1:0]      entry_id;
    logic [PRIO_IN_W-1:0] entry_priority;
    logic [TAG_W-1:0]     entry_tag;
    logic [OCC_W-1:0]     occupancy;
  } pqrm_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_REM,
    ST_FIN
  } pqrm_state_t;

  typedef enum logic {
    CMP_PRIO_LT,
    CMP_ID_EQ
  } pqrm_cmp_mode_t;

endpackage

// File: hdl/pqrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pqrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/pqrm_cmp.sv
// Shared compare unit: priority order for insert, id match for remove.
`timescale 1ns / 1ps
module pqrm_cmp
  import pqrm_pkg::*;
#(
  parameter int PW = 8
) (
  input  pqrm_cmp_mode_t  mode,
  input  logic [PW-1:0]   stored_prio,
  input  logic [PW-1:0]   key_prio,
  input  logic [ID_W-1:0] stored_id,
  input  logic [ID_W-1:0] key_id,
  output logic            hit
);

  always_comb begin
    unique case (mode)
      CMP_PRIO_LT: hit = stored_prio < key_prio;
      CMP_ID_EQ:   hit = stored_id == key_id;
      default:     hit = 1'b0;
    endcase
  end

endmodule

// File: hdl/pqrm_ctrl.sv
// Sequencer that walks the slot RAM one entry per cycle for insert, pop and remove.
`timescale 1ns / 1ps
module pqrm_ctrl
  import pqrm_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [ID_W-1:0] cfg_first_id,
  input  logic            in_valid,
  output logic            in_ready,
  input  pqrm_in_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output pqrm_out_t       out_data
);

  localparam int PW = (PRIORITY_BITS < PRIO_IN_W) ? PRIORITY_BITS : PRIO_IN_W;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = PW + ID_W + TAG_W;

  pqrm_state_t     state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [ID_W-1:0] next_id_r, next_id_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic            pend_r, pend_nxt;
  logic            found_r, found_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [ACT_W-1:0] act_r, act_nxt;
  logic [PW-1:0]   rprio_r, rprio_nxt;
  logic [TAG_W-1:0] rtag_r, rtag_nxt;
  logic [ID_W-1:0] rsid_r, rsid_nxt;
  pqrm_out_t       res_r, res_nxt;
  pqrm_out_t       out_r, out_nxt;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [EW-1:0]   mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [EW-1:0]   mem_rdata;

  logic [PW-1:0]   d_prio;
  logic [ID_W-1:0] d_id;
  logic [TAG_W-1:0] d_tag;
  pqrm_cmp_mode_t  cmp_mode;
  logic            cmp_hit;
  logic            match;
  logic            last;
  logic            full;

  assign d_prio = mem_rdata[EW-1 -: PW];
  assign d_id   = mem_rdata[TAG_W +: ID_W];
  assign d_tag  = mem_rdata[TAG_W-1:0];

  assign cmp_mode = (act_r == ACT_INSERT) ? CMP_PRIO_LT : CMP_ID_EQ;
  assign match    = (act_r == ACT_POP) ? (ptr_r == '0) : cmp_hit;
  assign last     = (CW'(ptr_r) + CW'(1)) == count_r;
  assign full     = count_r == CW'(CAPACITY);

  pqrm_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  pqrm_cmp #(
    .PW(PW)
  ) u_cmp (
    .mode       (cmp_mode),
    .stored_prio(d_prio),
    .key_prio   (rprio_r),
    .stored_id  (d_id),
    .key_id     (rsid_r),
    .hit        (cmp_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      next_id_r   <= FIRST_ID_RST;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      next_id_r   <= next_id_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    act_r   <= act_nxt;
    rprio_r <= rprio_nxt;
    rtag_r  <= rtag_nxt;
    rsid_r  <= rsid_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    next_id_nxt   = next_id_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    act_nxt       = act_r;
    rprio_nxt     = rprio_r;
    rtag_nxt      = rtag_r;
    rsid_nxt      = rsid_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = mem_rdata;
    mem_raddr     = ptr_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_data.action;
          rprio_nxt = in_data.priority_req[PW-1:0];
          rtag_nxt  = in_data.tag;
          rsid_nxt  = in_data.search_id;
          res_nxt   = '0;
          res_nxt.occupancy = OCC_W'(count_r);
          found_nxt = 1'b0;
          state_nxt = ST_FIN;
          case (in_data.action) inside
            ACT_INSERT: begin
              if (!full) begin
                state_nxt = ST_INS;
                if (count_r == '0) begin
                  ptr_nxt  = '0;
                  pend_nxt = 1'b0;
                end else begin
                  ptr_nxt   = AW'(count_r - CW'(1));
                  mem_raddr = ptr_nxt;
                  pend_nxt  = 1'b1;
                end
              end
            end
            ACT_POP, ACT_REMOVE: begin
              if (count_r != '0) begin
                state_nxt = ST_REM;
                ptr_nxt   = '0;
                mem_raddr = '0;
                pend_nxt  = 1'b1;
              end
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_INS: begin
        if (pend_r && cmp_hit) begin
          // entry has lower priority: move it one slot toward the tail
          mem_we    = 1'b1;
          mem_waddr = AW'(ptr_r + 1'b1);
          mem_wdata = mem_rdata;
          if (ptr_r == '0) begin
            pend_nxt = 1'b0;
          end else begin
            ptr_nxt   = AW'(ptr_r - 1'b1);
            mem_raddr = ptr_nxt;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = pend_r ? AW'(ptr_r + 1'b1) : ptr_r;
          mem_wdata = {rprio_r, next_id_r, rtag_r};
          count_nxt = count_r + CW'(1);
          next_id_nxt = next_id_r + ID_W'(1);
          res_nxt.ok        = 1'b1;
          res_nxt.entry_id  = next_id_r;
          res_nxt.occupancy = OCC_W'(count_nxt);
          pend_nxt  = 1'b0;
          state_nxt = ST_FIN;
        end
      end
      ST_REM: begin
        if (found_r) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(ptr_r - 1'b1);
          mem_wdata = mem_rdata;
        end else if (match) begin
          found_nxt = 1'b1;
          res_nxt.entry_id       = d_id;
          res_nxt.entry_priority = PRIO_IN_W'(d_prio);
          res_nxt.entry_tag      = d_tag;
        end
        if (last) begin
          pend_nxt  = 1'b0;
          state_nxt = ST_FIN;
          if (found_r || match) begin
            count_nxt         = count_r - CW'(1);
            res_nxt.ok        = 1'b1;
            res_nxt.occupancy = OCC_W'(count_nxt);
          end else begin
            res_nxt = '0;
            res_nxt.occupancy = OCC_W'(count_r);
          end
        end else begin
          ptr_nxt   = AW'(ptr_r + 1'b1);
          mem_raddr = ptr_nxt;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      next_id_nxt = cfg_first_id;
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_INS || state_r == ST_REM) && pend_r) |-> CW'(ptr_r) < count_r)
    else $error("walk pointer outside held entries");

  a_rem_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REM && found_r) |-> mem_we)
    else $error("entry behind removed slot not moved up");

  a_id_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cfg_we) && next_id_r != $past(next_id_r))
      |-> $past(state_r) == ST_INS)
    else $error("id counter moved outside an insert");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && !out_ready) |=> state_r == ST_FIN)
    else $error("result dropped while output register full");
`endif

endmodule

// File: hdl/priority_queue_remove_by_id.sv
// Top level: bounded priority queue with remove by id and APB configuration.
//
//  channel  direction  handshake                      payload
//  in_      input      in_valid / in_ready            pqrm_in_t
//  out_     output     out_valid / out_ready          pqrm_out_t
//  cfg_     APB        cfg_psel / cfg_penable         first_id at byte 0
//
// Insert: entries of lower priority are moved toward the tail, one at a time, until the new slot is found.
// Pop and remove by id: every held entry is read once.
// Refused items skip the walk. All entries share one RAM read and one write port.
// Results wait in an output register; the next item is taken meanwhile.
// Reset is synchronous; slot contents are not cleared, no clearing pass.
`timescale 1ns / 1ps
module priority_queue_remove_by_id
  import pqrm_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pqrm_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pqrm_out_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [ID_W-1:0] first_id_r, first_id_nxt;
  logic            cfg_we;

  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                  && (cfg_paddr[2] == REG_FIRST_ID);

  assign first_id_nxt = cfg_we ? cfg_pwdata[ID_W-1:0] : first_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_id_r <= FIRST_ID_RST;
    end else begin
      first_id_r <= first_id_nxt;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_FIRST_ID) ? APB_DW'(first_id_r) : '0;

  pqrm_ctrl #(
    .CAPACITY     (CAPACITY),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_first_id(first_id_nxt),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
